// ===== rtl/assert_macros.svh =====
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, masked while reset is high.
`define SWD_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("%m: assertion failed");

// Clocked assertion that also holds through reset.
`define SWD_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("%m: assertion failed");

`endif

// ===== rtl/swd_pkg.sv =====
// Package: types and constants for the stack with delete by value.
`default_nettype none

package swd_pkg;

  localparam int DEPTH  = 32;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    MODE_PUSH = 2'd0,
    MODE_POP  = 2'd1,
    MODE_DEL  = 2'd2,
    MODE_LIST = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    KIND_POP   = 3'd0,
    KIND_LIST  = 3'd1,
    KIND_EMPTY = 3'd2,
    KIND_UNDER = 3'd3,
    KIND_OVER  = 3'd4
  } kind_t;

  typedef struct packed {
    mode_t              mode;
    logic signed [31:0] value;
  } in_t;

  typedef struct packed {
    kind_t              kind;
    logic signed [31:0] data;
    logic               last;
  } out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_POP,
    ST_LIST,
    ST_DEL_SCAN,
    ST_DEL_SHIFT
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/stack_with_delete_by_value_unit.sv =====
// Top level: LIFO stack in a synchronous RAM with pop, push, delete by value and list.
// Push: no busy time; the overflow beat comes in the cycle after start.
// Pop: the RAM read is registered, then the beat is registered out of ST_POP; busy in ST_POP.
// List/delete: walk the RAM one entry a cycle, busy until the walk ends; list beats
//   follow one a cycle, each registered out of ST_LIST after its RAM read.
// Synchronous reset empties the stack at once; RAM contents are not cleared.
`default_nettype none

module stack_with_delete_by_value_unit (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire swd_pkg::in_t  item,
  output logic               busy,
  output logic               strobe,
  output swd_pkg::out_t      result
);
  import swd_pkg::*;

  logic signed [31:0] mem [DEPTH];
  logic signed [31:0] rdata;

  state_t             state, state_next;
  logic [CNT_W-1:0]   count, count_next;
  logic [ADDR_W-1:0]  rptr, rptr_next;
  logic signed [31:0] val_q;
  logic               strobe_next;
  out_t               res_next;

  logic               rd_en;
  logic [ADDR_W-1:0]  rd_addr;
  logic               wr_en;
  logic [ADDR_W-1:0]  wr_addr;
  logic signed [31:0] wr_data;

  logic               accept, empty, full, at_end, hit;
  logic [ADDR_W-1:0]  rptr_inc;

  assign busy     = (state != ST_IDLE);
  assign accept   = start && !busy;
  assign empty    = (count == '0);
  assign full     = (count == CNT_W'(DEPTH));
  assign rptr_inc = rptr + ADDR_W'(1);
  assign at_end   = ((CNT_W'(rptr) + CNT_W'(1)) == count);
  assign hit      = (rdata == val_q);

  // RAM
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (item.mode)
            MODE_PUSH: state_next = ST_IDLE;
            MODE_POP:  state_next = empty ? ST_IDLE : ST_POP;
            MODE_DEL:  state_next = empty ? ST_IDLE : ST_DEL_SCAN;
            MODE_LIST: state_next = empty ? ST_IDLE : ST_LIST;
            default:   state_next = ST_IDLE;
          endcase
        end
      end
      ST_POP:       state_next = ST_IDLE;
      ST_LIST:      state_next = at_end ? ST_IDLE : ST_LIST;
      ST_DEL_SCAN: begin
        if (at_end) begin
          state_next = ST_IDLE;
        end else if (hit) begin
          state_next = ST_DEL_SHIFT;
        end
      end
      ST_DEL_SHIFT: state_next = at_end ? ST_IDLE : ST_DEL_SHIFT;
      default:      state_next = ST_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    rd_en       = 1'b0;
    rd_addr     = rptr_inc;
    wr_en       = 1'b0;
    wr_addr     = count[ADDR_W-1:0];
    wr_data     = item.value;
    count_next  = count;
    rptr_next   = rptr;
    strobe_next = 1'b0;
    res_next    = result;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (item.mode)
            MODE_PUSH: begin
              if (full) begin
                strobe_next = 1'b1;
                res_next    = '{kind: KIND_OVER, data: '0, last: 1'b1};
              end else begin
                wr_en      = 1'b1;
                count_next = count + CNT_W'(1);
              end
            end
            MODE_POP: begin
              if (empty) begin
                strobe_next = 1'b1;
                res_next    = '{kind: KIND_UNDER, data: '0, last: 1'b1};
              end else begin
                rd_en      = 1'b1;
                rd_addr    = ADDR_W'(count - CNT_W'(1));
                count_next = count - CNT_W'(1);
              end
            end
            MODE_DEL: begin
              if (!empty) begin
                rd_en     = 1'b1;
                rd_addr   = '0;
                rptr_next = '0;
              end
            end
            MODE_LIST: begin
              if (empty) begin
                strobe_next = 1'b1;
                res_next    = '{kind: KIND_EMPTY, data: '0, last: 1'b1};
              end else begin
                rd_en     = 1'b1;
                rd_addr   = '0;
                rptr_next = '0;
              end
            end
            default: ;
          endcase
        end
      end
      ST_POP: begin
        strobe_next = 1'b1;
        res_next    = '{kind: KIND_POP, data: rdata, last: 1'b1};
      end
      ST_LIST: begin
        strobe_next = 1'b1;
        res_next    = '{kind: KIND_LIST, data: rdata, last: at_end};
        if (!at_end) begin
          rd_en     = 1'b1;
          rptr_next = rptr_inc;
        end
      end
      ST_DEL_SCAN: begin
        if (hit && at_end) begin
          count_next = count - CNT_W'(1);
        end else if (!at_end) begin
          rd_en     = 1'b1;
          rptr_next = rptr_inc;
        end
      end
      ST_DEL_SHIFT: begin
        // entry rptr moves down one place
        wr_en   = 1'b1;
        wr_addr = rptr - ADDR_W'(1);
        wr_data = rdata;
        if (at_end) begin
          count_next = count - CNT_W'(1);
        end else begin
          rd_en     = 1'b1;
          rptr_next = rptr_inc;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      count  <= '0;
      strobe <= 1'b0;
    end else begin
      state  <= state_next;
      count  <= count_next;
      strobe <= strobe_next;
    end
  end

  always_ff @(posedge clk) begin
    rptr   <= rptr_next;
    result <= res_next;
    if (accept) begin
      val_q <= item.value;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/swd_checker.sv =====
// Checker: port-level assertions for the stack unit, bound to the top level.
`default_nettype none
`include "assert_macros.svh"

module swd_checker (
  input wire logic          clk,
  input wire logic          rst,
  input wire logic          start,
  input wire swd_pkg::in_t  item,
  input wire logic          busy,
  input wire logic          strobe,
  input wire swd_pkg::out_t result
);
  import swd_pkg::*;

  `SWD_ASSERT_ALWAYS(a_no_beat_after_rst, clk, rst |=> !strobe)

  `SWD_ASSERT(a_marker_zero, clk, rst, strobe && (result.kind == KIND_EMPTY || result.kind == KIND_UNDER || result.kind == KIND_OVER) |-> result.data == '0)

  `SWD_ASSERT(a_single_beat_last, clk, rst, strobe && result.kind != KIND_LIST |-> result.last)

  `SWD_ASSERT(a_pop_answers, clk, rst, start && !busy && item.mode == MODE_POP |=> busy || strobe)

  `SWD_ASSERT(a_list_beats_busy, clk, rst, strobe && result.kind == KIND_LIST && !result.last |-> busy)

endmodule

bind stack_with_delete_by_value_unit swd_checker u_swd_checker (.*);

`default_nettype wire

// ===== verif/stack_with_delete_by_value_unit_tb.sv =====
// Self-checking testbench for the stack with delete by value: directed table, then random ops.
`timescale 1ns / 1ps

module stack_with_delete_by_value_unit_tb;
  import swd_pkg::*;

  typedef struct packed {
    mode_t       mode;
    logic [31:0] value;
    logic [5:0]  reps;
    logic        typed;
    kind_t       kind;
    logic [31:0] data;
  } row_t;

  localparam int NROWS = 27;

  // reps > 1 pushes value, value+1, ...; typed rows carry their single beat
  localparam row_t DIR_TAB [0:NROWS-1] = '{
    '{MODE_LIST, 32'h0000_0000, 6'd1,  1'b1, KIND_EMPTY, 32'h0000_0000},
    '{MODE_POP,  32'h0000_0000, 6'd1,  1'b1, KIND_UNDER, 32'h0000_0000},
    '{MODE_DEL,  32'h0000_0005, 6'd1,  1'b0, KIND_POP,   32'h0000_0000},
    '{MODE_PUSH, 32'h7fff_ffff, 6'd1,  1'b0, KIND_POP,   32'h0000_0000},
    '{MODE_PUSH, 32'h8000_0000, 6'd1,  1'b0, KIND_POP,   32'h0000_0000},
    '{MODE_PUSH, 32'h0000_0000, 6'd1,  1'b0, KIND_POP,   32'h0000_0000},
    '{MODE_PUSH, 32'hffff_ffff, 6'd1,  1'b0, KIND_POP,   32'h0000_0000},
    '{MODE_LIST, 32'h0000_0000, 6'd1,  1'b0, KIND_POP,   32'h0000_0000},
    '{MODE_DEL,  32'h0000_0000, 6'd1,  1'b0, KIND_POP,   32'h0000_0000},
    '{MODE_DEL,  32'h0000_3039, 6'd1,  1'b0, KIND_POP,   32'h0000_0000},
    '{MODE_POP,  32'h0000_0000, 6'd1,  1'b1, KIND_POP,   32'hffff_ffff},
    '{MODE_PUSH, 32'h0000_0007, 6'd1,  1'b0, KIND_POP,   32'h0000_0000},
    '{MODE_PUSH, 32'h0000_0007, 6'd1,  1'b0, KIND_POP,   32'h0000_0000},
    '{MODE_PUSH, 32'h0000_0009, 6'd1,  1'b0, KIND_POP,   32'h0000_0000},
    '{MODE_DEL,  32'h0000_0007, 6'd1,  1'b0, KIND_POP,   32'h0000_0000},
    '{MODE_LIST, 32'h0000_0000, 6'd1,  1'b0, KIND_POP,   32'h0000_0000},
    '{MODE_DEL,  32'h0000_0009, 6'd1,  1'b0, KIND_POP,   32'h0000_0000},
    '{MODE_DEL,  32'h7fff_ffff, 6'd1,  1'b0, KIND_POP,   32'h0000_0000},
    '{MODE_POP,  32'h0000_0000, 6'd1,  1'b0, KIND_POP,   32'h0000_0000},
    '{MODE_POP,  32'h0000_0000, 6'd1,  1'b1, KIND_POP,   32'h8000_0000},
    '{MODE_POP,  32'h0000_0000, 6'd1,  1'b1, KIND_UNDER, 32'h0000_0000},
    '{MODE_PUSH, 32'h0000_03e8, 6'd32, 1'b0, KIND_POP,   32'h0000_0000},
    '{MODE_PUSH, 32'h0000_0037, 6'd1,  1'b1, KIND_OVER,  32'h0000_0000},
    '{MODE_LIST, 32'h0000_0000, 6'd1,  1'b0, KIND_POP,   32'h0000_0000},
    '{MODE_DEL,  32'h0000_03e8, 6'd1,  1'b0, KIND_POP,   32'h0000_0000},
    '{MODE_DEL,  32'h0000_0407, 6'd1,  1'b0, KIND_POP,   32'h0000_0000},
    '{MODE_LIST, 32'h0000_0000, 6'd1,  1'b0, KIND_POP,   32'h0000_0000}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  in_t  item = '0;
  logic busy;
  logic strobe;
  out_t result;

  // typed expectation travelling with the current item
  logic exp_typed = 1'b0;
  out_t exp_want = '0;

  logic signed [31:0] stk [DEPTH];
  int   fill = 0;
  out_t beats [$];
  out_t beats_due [$];
  out_t due_beat;
  int   errors = 0;

  logic [31:0] recent [$];
  int   sent = 0;
  bit   idle_on = 1'b1;

  stack_with_delete_by_value_unit u_top (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .item   (item),
    .busy   (busy),
    .strobe (strobe),
    .result (result)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Stack behaviour for one item; fills beats with what it should return.
  task automatic stack_apply(input in_t it);
    int i;
    bit hit;
    beats.delete();
    hit = 1'b0;
    case (it.mode)
      MODE_PUSH: begin
        if (fill >= DEPTH) begin
          beats.push_back(out_t'{KIND_OVER, 32'sd0, 1'b1});
        end else begin
          stk[fill] = it.value;
          fill++;
        end
      end
      MODE_POP: begin
        if (fill == 0) begin
          beats.push_back(out_t'{KIND_UNDER, 32'sd0, 1'b1});
        end else begin
          fill--;
          beats.push_back(out_t'{KIND_POP, stk[fill], 1'b1});
        end
      end
      MODE_DEL: begin
        for (i = 0; i < fill; i++) begin
          if (hit) begin
            stk[i-1] = stk[i];
          end else if (stk[i] == it.value) begin
            hit = 1'b1;
          end
        end
        if (hit) fill--;
      end
      default: begin
        if (fill == 0) begin
          beats.push_back(out_t'{KIND_EMPTY, 32'sd0, 1'b1});
        end else begin
          for (i = 0; i < fill; i++)
            beats.push_back(out_t'{KIND_LIST, stk[i], logic'(i == fill - 1)});
        end
      end
    endcase
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (strobe) begin
        if (beats_due.size() == 0) begin
          $error("result beat with none due: kind %0d data %0d last %0d",
                 result.kind, result.data, result.last);
          errors++;
        end else begin
          due_beat = beats_due.pop_front();
          if (result.kind !== due_beat.kind) begin
            $error("kind: expected %0d, got %0d", due_beat.kind, result.kind);
            errors++;
          end
          if (result.data !== due_beat.data) begin
            $error("data: expected %0d, got %0d", due_beat.data, result.data);
            errors++;
          end
          if (result.last !== due_beat.last) begin
            $error("last: expected %0d, got %0d", due_beat.last, result.last);
            errors++;
          end
        end
      end
      if (start && !busy) begin
        stack_apply(item);
        if (exp_typed) begin
          beats_due.push_back(exp_want);
        end else begin
          foreach (beats[i]) beats_due.push_back(beats[i]);
        end
      end
    end
  end

  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 9))
      0, 1, 2: return $urandom_range(0, 7) - 4;
      3: begin
        case ($urandom_range(0, 3))
          0: return 32'h7fff_ffff;
          1: return 32'h8000_0000;
          2: return 32'h0000_0000;
          default: return 32'hffff_ffff;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_recent();
    if (recent.size() == 0) return rand_value();
    return recent[$urandom_range(0, recent.size() - 1)];
  endfunction

  task automatic send(input in_t it, input bit typed, input out_t want);
    start <= 1'b1;
    item <= it;
    exp_typed <= typed;
    exp_want <= want;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (it.mode == MODE_PUSH) begin
      recent.push_back(it.value);
      if (recent.size() > 48) void'(recent.pop_front());
    end
    if (idle_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
  endtask

  task automatic issue(input mode_t m, input logic [31:0] v, input bit counted);
    send(in_t'{m, v}, 1'b0, '0);
    if (counted) sent++;
  endtask

  initial begin
    int r;
    int k;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    for (r = 0; r < NROWS; r++) begin
      for (k = 0; k < DIR_TAB[r].reps; k++) begin
        send(in_t'{DIR_TAB[r].mode, DIR_TAB[r].value + k}, DIR_TAB[r].typed,
             out_t'{DIR_TAB[r].kind, DIR_TAB[r].data, 1'b1});
        sent++;
      end
    end

    while (sent < 250) begin
      idle_on = (sent < 200) && ($urandom_range(0, 2) != 0);
      case ($urandom_range(0, 7))
        0: repeat ($urandom_range(8, DEPTH + 3)) issue(MODE_PUSH, rand_value(), 1'b1);
        1: begin
          repeat ($urandom_range(4, DEPTH + 2)) issue(MODE_POP, $urandom, 1'b1);
          issue(MODE_LIST, $urandom, 1'b1);
        end
        2: begin
          repeat ($urandom_range(2, 6)) issue(MODE_PUSH, $urandom_range(0, 3), 1'b1);
          repeat ($urandom_range(1, 4)) issue(MODE_DEL, pick_recent(), 1'b1);
          issue(MODE_LIST, $urandom, 1'b1);
        end
        default: begin
          repeat ($urandom_range(1, 12)) begin
            case ($urandom_range(0, 9))
              0, 1, 2, 3: issue(MODE_PUSH, rand_value(), 1'b1);
              4, 5: issue(MODE_POP, $urandom, 1'b1);
              6, 7: issue(MODE_DEL, pick_recent(), 1'b1);
              8: issue(MODE_DEL, rand_value(), 1'b1);
              default: issue(MODE_LIST, $urandom, 1'b1);
            endcase
          end
        end
      endcase
    end

    start <= 1'b0;
    while (beats_due.size() != 0) @(posedge clk);
    repeat (DEPTH + 8) @(posedge clk);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("status: fail");
    $finish;
  end

endmodule
